[hw/rtl/lpg_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the line pixel generator.
// Depends on nothing; used by lpg_step, line_pixel_generator_core and the testbench.
package lpg_pkg;

   // Default coordinate width of the ports and position registers.
   localparam int COORD_BITS_DEF = 16;

   // Command codes carried on the request opcode.
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Drawing mode, one-hot.
   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_COLUMN = 4'b0010,
      MODE_ROW    = 4'b0100,
      MODE_WALK   = 4'b1000
   } mode_type;

   // Control state of the line walker.
   typedef struct packed {
      mode_type mode;
      logic     x_dir_neg;
      logic     y_dir_neg;
   } ctl_type;

   // Status of one processed command.
   typedef struct packed {
      logic valid;
      logic last;
   } res_type;

endpackage

[hw/rtl/lpg_step.sv]
`timescale 1ns / 1ps
// Next-state and pixel logic of the line pixel generator for one command.
// Depends on lpg_pkg (mode, control and result types, opcodes).
module lpg_step #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  logic                          cmd_op,
   input  logic signed [COORD_BITS-1:0]  cmd_x_start,
   input  logic signed [COORD_BITS-1:0]  cmd_y_start,
   input  logic signed [COORD_BITS-1:0]  cmd_x_end,
   input  logic signed [COORD_BITS-1:0]  cmd_y_end,
   input  lpg_pkg::ctl_type              ctl_cur,
   input  logic        [COORD_BITS-1:0]  cur_x,
   input  logic        [COORD_BITS-1:0]  cur_y,
   input  logic        [COORD_BITS-1:0]  target_x,
   input  logic        [COORD_BITS-1:0]  target_y,
   input  logic        [COORD_BITS:0]    span_w,
   input  logic        [COORD_BITS:0]    span_h,
   input  logic signed [COORD_BITS+2:0]  error_term,
   input  logic        [COORD_BITS:0]    pixels_left,
   output lpg_pkg::ctl_type              ctl_next,
   output logic        [COORD_BITS-1:0]  cur_x_next,
   output logic        [COORD_BITS-1:0]  cur_y_next,
   output logic        [COORD_BITS-1:0]  target_x_next,
   output logic        [COORD_BITS-1:0]  target_y_next,
   output logic        [COORD_BITS:0]    span_w_next,
   output logic        [COORD_BITS:0]    span_h_next,
   output logic signed [COORD_BITS+2:0]  error_term_next,
   output logic        [COORD_BITS:0]    pixels_left_next,
   output lpg_pkg::res_type              res,
   output logic        [COORD_BITS-1:0]  res_x,
   output logic        [COORD_BITS-1:0]  res_y
);

   localparam int SPAN_BITS = COORD_BITS + 1;
   localparam int ERR_BITS  = COORD_BITS + 3;
   localparam int E2_BITS   = ERR_BITS + 1;

   logic signed [SPAN_BITS-1:0] dx;
   logic signed [SPAN_BITS-1:0] dy;
   logic        [SPAN_BITS-1:0] w_new;
   logic        [SPAN_BITS-1:0] h_new;
   logic        [SPAN_BITS-1:0] span_max;
   logic                        x_lt;
   logic                        y_lt;
   logic        [COORD_BITS-1:0] x_min;
   logic        [COORD_BITS-1:0] y_min;
   logic signed [E2_BITS-1:0]   e2;
   logic signed [E2_BITS-1:0]   w_ext;
   logic signed [E2_BITS-1:0]   h_ext;
   logic                        move_x;
   logic                        move_y;
   logic        [SPAN_BITS-1:0] left_dec;

   // Endpoint differences and spans for a start command.
   assign dx    = {cmd_x_start[COORD_BITS-1], cmd_x_start} - {cmd_x_end[COORD_BITS-1], cmd_x_end};
   assign dy    = {cmd_y_start[COORD_BITS-1], cmd_y_start} - {cmd_y_end[COORD_BITS-1], cmd_y_end};
   assign w_new = dx[SPAN_BITS-1] ? SPAN_BITS'(-dx) : SPAN_BITS'(dx);
   assign h_new = dy[SPAN_BITS-1] ? SPAN_BITS'(-dy) : SPAN_BITS'(dy);
   assign span_max = (w_new > h_new) ? w_new : h_new;
   assign x_lt  = cmd_x_start < cmd_x_end;
   assign y_lt  = cmd_y_start < cmd_y_end;
   assign x_min = x_lt ? cmd_x_start : cmd_x_end;
   assign y_min = y_lt ? cmd_y_start : cmd_y_end;

   // Error-term decisions for one walk step.
   assign e2     = {error_term, 1'b0};
   assign w_ext  = $signed({3'b000, span_w});
   assign h_ext  = $signed({3'b000, span_h});
   assign move_x = e2 > -h_ext;
   assign move_y = e2 < w_ext;

   assign left_dec = pixels_left - SPAN_BITS'(1);

   always_comb begin
      ctl_next         = ctl_cur;
      cur_x_next       = cur_x;
      cur_y_next       = cur_y;
      target_x_next    = target_x;
      target_y_next    = target_y;
      span_w_next      = span_w;
      span_h_next      = span_h;
      error_term_next  = error_term;
      pixels_left_next = pixels_left;
      res.valid        = 1'b0;
      res.last         = 1'b0;
      res_x            = cur_x;
      res_y            = cur_y;

      if (cmd_op == lpg_pkg::OP_START) begin
         span_w_next        = w_new;
         span_h_next        = h_new;
         ctl_next.x_dir_neg = !x_lt;
         ctl_next.y_dir_neg = !y_lt;
         target_x_next      = cmd_x_end;
         target_y_next      = cmd_y_end;
         error_term_next    = $signed({2'b00, w_new}) - $signed({2'b00, h_new});
         if (w_new <= SPAN_BITS'(1)) begin
            cur_x_next       = x_min;
            cur_y_next       = y_min;
            pixels_left_next = h_new;
            ctl_next.mode    = (h_new != '0) ? lpg_pkg::MODE_COLUMN : lpg_pkg::MODE_IDLE;
         end else if (h_new <= SPAN_BITS'(1)) begin
            cur_x_next       = x_min;
            cur_y_next       = y_min;
            pixels_left_next = w_new;
            ctl_next.mode    = lpg_pkg::MODE_ROW;
         end else begin
            // Walk covers the longer span with both ends included.
            cur_x_next       = cmd_x_start;
            cur_y_next       = cmd_y_start;
            pixels_left_next = span_max + SPAN_BITS'(1);
            ctl_next.mode    = lpg_pkg::MODE_WALK;
         end
      end else begin
         unique case (ctl_cur.mode)
            lpg_pkg::MODE_IDLE: begin
               res.valid = 1'b0;
            end
            lpg_pkg::MODE_COLUMN, lpg_pkg::MODE_ROW: begin
               res.valid = 1'b1;
               if (ctl_cur.mode == lpg_pkg::MODE_COLUMN) begin
                  cur_y_next = cur_y + COORD_BITS'(1);
               end else begin
                  cur_x_next = cur_x + COORD_BITS'(1);
               end
               pixels_left_next = left_dec;
               if (left_dec == '0) begin
                  res.last      = 1'b1;
                  ctl_next.mode = lpg_pkg::MODE_IDLE;
               end
            end
            lpg_pkg::MODE_WALK: begin
               res.valid = 1'b1;
               if (cur_x == target_x && cur_y == target_y) begin
                  res.last         = 1'b1;
                  ctl_next.mode    = lpg_pkg::MODE_IDLE;
                  pixels_left_next = '0;
               end else begin
                  error_term_next = ERR_BITS'(E2_BITS'(error_term)
                                    - (move_x ? h_ext : E2_BITS'(0))
                                    + (move_y ? w_ext : E2_BITS'(0)));
                  if (move_x) begin
                     cur_x_next = ctl_cur.x_dir_neg ? cur_x - COORD_BITS'(1)
                                                    : cur_x + COORD_BITS'(1);
                  end
                  if (move_y) begin
                     cur_y_next = ctl_cur.y_dir_neg ? cur_y - COORD_BITS'(1)
                                                    : cur_y + COORD_BITS'(1);
                  end
                  if (pixels_left != '0) begin
                     pixels_left_next = left_dec;
                  end
               end
            end
            default: begin
               ctl_next.mode = lpg_pkg::MODE_IDLE;
            end
         endcase
      end
   end

endmodule

[hw/rtl/line_pixel_generator_core.sv]
`timescale 1ns / 1ps
// Line pixel generator top level: command register, walker state, pixel register.
// Depends on lpg_pkg and lpg_step.
//
// Usage:
//   The req_ channel carries commands. A start command (opcode 0) latches two
//   endpoints and a color and produces no pixel. Each step command (opcode 1)
//   produces the next pixel of the current line on the rsp_ channel, or nothing
//   when the line is done. Short lines (|dx| <= 1 or |dy| <= 1) come out as a
//   column or row starting at the smaller coordinate, far end left out; other
//   lines come out as an error-term walk from start to end, both included.
//   A new start abandons the line in progress.
//   A step command passes through the command register, then the pixel register,
//   to rsp_. Throughput: one command per clock while no pixel is held by
//   rsp_stall; the single add-and-compare error-term update per pixel sets it.
//   A transfer happens at an edge where valid is high and stall is low.
//   When rsp_stall holds a pixel, the pixel register holds it; the command
//   register still drains start commands and steps that give no pixel, and
//   req_stall rises only when a pixel-producing step is waiting behind it.
//   Reset (synchronous, active high) empties both registers and leaves the
//   walker idle with all positions, spans and the color cleared.
module line_pixel_generator_core #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic signed [COORD_BITS-1:0] req_x_start,
   input  logic signed [COORD_BITS-1:0] req_y_start,
   input  logic signed [COORD_BITS-1:0] req_x_end,
   input  logic signed [COORD_BITS-1:0] req_y_end,
   input  logic        [31:0]           req_color_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic        [31:0]           rsp_pixel_color,
   output logic                         rsp_last_pixel
);

   localparam int SPAN_BITS = COORD_BITS + 1;
   localparam int ERR_BITS  = COORD_BITS + 3;

   // Command register.
   logic                  cmd_vld_ff, cmd_vld_in;
   logic                  cmd_op_ff;
   logic [COORD_BITS-1:0] cmd_x0_ff, cmd_y0_ff, cmd_x1_ff, cmd_y1_ff;
   logic [31:0]           cmd_color_ff;

   // Walker state.
   lpg_pkg::ctl_type      ctl_ff, ctl_in;
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic [SPAN_BITS-1:0]  span_w_ff, span_w_in, span_h_ff, span_h_in;
   logic signed [ERR_BITS-1:0] error_term_ff, error_term_in;
   logic [SPAN_BITS-1:0]  pixels_left_ff, pixels_left_in;
   logic [31:0]           line_color_ff;

   // Pixel register.
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [31:0]           rsp_color_ff;
   logic                  rsp_last_ff;

   lpg_pkg::res_type      res;
   logic [COORD_BITS-1:0] res_x, res_y;
   logic                  req_xfer;
   logic                  advance;
   logic                  gives_pixel;

   lpg_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .cmd_op           (cmd_op_ff),
      .cmd_x_start      ($signed(cmd_x0_ff)),
      .cmd_y_start      ($signed(cmd_y0_ff)),
      .cmd_x_end        ($signed(cmd_x1_ff)),
      .cmd_y_end        ($signed(cmd_y1_ff)),
      .ctl_cur          (ctl_ff),
      .cur_x            (cur_x_ff),
      .cur_y            (cur_y_ff),
      .target_x         (target_x_ff),
      .target_y         (target_y_ff),
      .span_w           (span_w_ff),
      .span_h           (span_h_ff),
      .error_term       (error_term_ff),
      .pixels_left      (pixels_left_ff),
      .ctl_next         (ctl_in),
      .cur_x_next       (cur_x_in),
      .cur_y_next       (cur_y_in),
      .target_x_next    (target_x_in),
      .target_y_next    (target_y_in),
      .span_w_next      (span_w_in),
      .span_h_next      (span_h_in),
      .error_term_next  (error_term_in),
      .pixels_left_next (pixels_left_in),
      .res              (res),
      .res_x            (res_x),
      .res_y            (res_y)
   );

   // Process the held command unless it makes a pixel the full pixel register
   // cannot take this cycle.
   assign gives_pixel = res.valid;
   assign advance     = cmd_vld_ff && (!gives_pixel || !rsp_vld_ff || !rsp_stall);
   assign req_stall   = cmd_vld_ff && !advance;
   assign req_xfer    = req_valid && !req_stall;

   assign cmd_vld_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : cmd_vld_ff);

   // Load a new pixel on a pixel-producing step; drop the old one once taken.
   always_comb begin
      priority if (advance && gives_pixel) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         cmd_vld_ff <= cmd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Command payload: capture on transfer, no reset.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_op_ff    <= req_opcode;
         cmd_x0_ff    <= req_x_start;
         cmd_y0_ff    <= req_y_start;
         cmd_x1_ff    <= req_x_end;
         cmd_y1_ff    <= req_y_end;
         cmd_color_ff <= req_color_in;
      end
   end

   // Walker state: advance on every processed command.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff         <= '{mode: lpg_pkg::MODE_IDLE, x_dir_neg: 1'b0, y_dir_neg: 1'b0};
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         target_x_ff    <= '0;
         target_y_ff    <= '0;
         span_w_ff      <= '0;
         span_h_ff      <= '0;
         error_term_ff  <= '0;
         pixels_left_ff <= '0;
         line_color_ff  <= '0;
      end else if (advance) begin
         ctl_ff         <= ctl_in;
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         target_x_ff    <= target_x_in;
         target_y_ff    <= target_y_in;
         span_w_ff      <= span_w_in;
         span_h_ff      <= span_h_in;
         error_term_ff  <= error_term_in;
         pixels_left_ff <= pixels_left_in;
         if (cmd_op_ff == lpg_pkg::OP_START) begin
            line_color_ff <= cmd_color_ff;
         end
      end
   end

   // Pixel payload: hold while stalled.
   always_ff @(posedge clock) begin
      if (advance && gives_pixel) begin
         rsp_x_ff     <= res_x;
         rsp_y_ff     <= res_y;
         rsp_color_ff <= line_color_ff;
         rsp_last_ff  <= res.last;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_pixel_x     = $signed(rsp_x_ff);
   assign rsp_pixel_y     = $signed(rsp_y_ff);
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

   // The final pixel of a line always leaves the walker idle.
   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && gives_pixel && res.last) |=> (ctl_ff.mode == lpg_pkg::MODE_IDLE))
      else $error("walker not idle after final pixel");

   // Column and row modes always have at least one pixel to give.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.mode == lpg_pkg::MODE_COLUMN || ctl_ff.mode == lpg_pkg::MODE_ROW)
      |-> (pixels_left_ff != '0))
      else $error("column or row mode with no pixels left");

   // Commands back up only behind a stalled, full pixel register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_vld_ff && rsp_stall && gives_pixel))
      else $error("command stalled without a stalled pixel");

   // A pixel is only loaded when the previous one is gone or being taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_stall) |-> !(advance && gives_pixel))
      else $error("stalled pixel overwritten");

endmodule

[verif/line_pixel_generator_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for line_pixel_generator_core: random line commands,
// random idling on both channels, pixels checked against an in-bench line walker.
// Depends on lpg_pkg and the line_pixel_generator_core RTL.
module line_pixel_generator_core_tb;

   localparam int CW          = lpg_pkg::COORD_BITS_DEF;
   localparam int QUIET_LIMIT = 3000;   // cycles with no transfer on either channel
   localparam int DRAIN_WAIT  = 8;      // pixel shows through the pixel register after its step
   localparam int HOLD_AFTER  = 300;    // accepted commands before the long hold-off
   localparam int HOLD_CYCLES = 80;
   localparam int CMD_TARGET  = 725;

   typedef struct {
      logic                 opcode;
      logic signed [CW-1:0] x_start;
      logic signed [CW-1:0] y_start;
      logic signed [CW-1:0] x_end;
      logic signed [CW-1:0] y_end;
      logic [31:0]          color;
   } line_cmd_type;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [31:0]          color;
      logic                 last;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_opcode;
   logic signed [CW-1:0] req_x_start;
   logic signed [CW-1:0] req_y_start;
   logic signed [CW-1:0] req_x_end;
   logic signed [CW-1:0] req_y_end;
   logic [31:0]          req_color_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [CW-1:0] rsp_pixel_x;
   logic signed [CW-1:0] rsp_pixel_y;
   logic [31:0]          rsp_pixel_color;
   logic                 rsp_last_pixel;

   line_cmd_type cmd_queue[$];
   pixel_type    pixel_queue[$];

   int   n_accepted  = 0;
   int   n_errors    = 0;
   int   total_cmds  = 0;
   int   cycle_cnt   = 0;
   int   quiet_cycles = 0;
   int   req_gap     = 0;
   int   stall_left  = 0;
   int   hold_left   = 0;
   bit   hold_done   = 0;
   logic req_taken   = 1'b0;

   // Line walker state, mirrors the block's own registers.
   lpg_pkg::mode_type line_mode;
   logic [CW-1:0] cur_x, cur_y, tgt_x, tgt_y;
   int          span_w, span_h, err_term, pix_left;
   logic        x_neg, y_neg;
   logic [31:0] line_color;

   line_pixel_generator_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_color_in    (req_color_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Line walker: advance on each accepted command, queue the pixel it gives.
   // ---------------------------------------------------------------------
   task automatic clear_walker();
      line_mode  = lpg_pkg::MODE_IDLE;
      cur_x      = '0;
      cur_y      = '0;
      tgt_x      = '0;
      tgt_y      = '0;
      span_w     = 0;
      span_h     = 0;
      err_term   = 0;
      pix_left   = 0;
      x_neg      = 1'b0;
      y_neg      = 1'b0;
      line_color = '0;
   endtask

   task automatic walk_line_cmd();
      int        ax1, ay1, ax2, ay2, dx, dy, xmin, ymin, e2;
      pixel_type p;
      if (req_opcode == lpg_pkg::OP_START) begin
         // Latch endpoints and pick column, row or error-term walk.
         ax1 = int'(req_x_start);
         ay1 = int'(req_y_start);
         ax2 = int'(req_x_end);
         ay2 = int'(req_y_end);
         dx = ax1 - ax2;
         dy = ay1 - ay2;
         xmin = (ax1 < ax2) ? ax1 : ax2;
         ymin = (ay1 < ay2) ? ay1 : ay2;
         span_w = (dx < 0) ? -dx : dx;
         span_h = (dy < 0) ? -dy : dy;
         line_color = req_color_in;
         x_neg = !(ax1 < ax2);
         y_neg = !(ay1 < ay2);
         tgt_x = ax2[CW-1:0];
         tgt_y = ay2[CW-1:0];
         err_term = span_w - span_h;
         if (span_w <= 1) begin
            cur_x = xmin[CW-1:0];
            cur_y = ymin[CW-1:0];
            pix_left = span_h;
            line_mode = (pix_left != 0) ? lpg_pkg::MODE_COLUMN : lpg_pkg::MODE_IDLE;
         end else if (span_h <= 1) begin
            cur_x = xmin[CW-1:0];
            cur_y = ymin[CW-1:0];
            pix_left = span_w;
            line_mode = lpg_pkg::MODE_ROW;
         end else begin
            cur_x = ax1[CW-1:0];
            cur_y = ay1[CW-1:0];
            pix_left = ((span_w > span_h) ? span_w : span_h) + 1;
            line_mode = lpg_pkg::MODE_WALK;
         end
         return;
      end

      if (line_mode == lpg_pkg::MODE_IDLE)
         return;

      p.x = cur_x;
      p.y = cur_y;
      p.color = line_color;
      p.last = 1'b0;

      if (line_mode == lpg_pkg::MODE_COLUMN || line_mode == lpg_pkg::MODE_ROW) begin
         if (line_mode == lpg_pkg::MODE_COLUMN)
            cur_y = cur_y + 1'b1;
         else
            cur_x = cur_x + 1'b1;
         if (pix_left > 0)
            pix_left--;
         if (pix_left == 0) begin
            p.last = 1'b1;
            line_mode = lpg_pkg::MODE_IDLE;
         end
      end else if (cur_x == tgt_x && cur_y == tgt_y) begin
         p.last = 1'b1;
         line_mode = lpg_pkg::MODE_IDLE;
         pix_left = 0;
      end else begin
         e2 = 2 * err_term;
         if (e2 > -span_h) begin
            err_term -= span_h;
            cur_x = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
         end
         if (e2 < span_w) begin
            err_term += span_w;
            cur_y = y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
         end
         if (pix_left > 0)
            pix_left--;
      end
      pixel_queue.push_back(p);
   endtask

   task automatic check_pixel();
      pixel_type p;
      if (pixel_queue.size() == 0) begin
         $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
                  rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel);
         n_errors++;
         return;
      end
      p = pixel_queue.pop_front();
      if (rsp_pixel_x !== p.x || rsp_pixel_y !== p.y || rsp_pixel_color !== p.color ||
          rsp_last_pixel !== p.last) begin
         $display("%0t: pixel mismatch expected x=%0d y=%0d color=%h last=%b", $time,
                  p.x, p.y, p.color, p.last);
         $display("%0t:                actual   x=%0d y=%0d color=%h last=%b", $time,
                  rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel);
         n_errors++;
      end
   endtask

   // Check the output before predicting, so a pixel can never match a step
   // accepted at the same edge.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (reset) begin
         clear_walker();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_pixel();
         if (req_valid && !req_stall) begin
            walk_line_cmd();
            n_accepted++;
         end
      end
      req_taken <= !reset && req_valid && !req_stall;
   end

   // Abort when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Idling: mostly short gaps, a few long ones, and calm stretches with none.
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if ((cycle_cnt / 256) % 4 == 3)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Request driver: hold the payload until transferred, then idle or advance.
   always @(negedge clock) begin : drive_req
      line_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_valid <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            c = cmd_queue.pop_front();
            req_opcode   <= c.opcode;
            req_x_start  <= c.x_start;
            req_y_start  <= c.y_start;
            req_x_end    <= c.x_end;
            req_y_end    <= c.y_end;
            req_color_in <= c.color;
            req_valid    <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off so the block backs up
   // and stalls its input while the driver keeps offering commands.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap();
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic queue_start(input int x1, input int y1, input int x2, input int y2,
                              input logic [31:0] color);
      line_cmd_type c;
      c.opcode  = lpg_pkg::OP_START;
      c.x_start = x1[CW-1:0];
      c.y_start = y1[CW-1:0];
      c.x_end   = x2[CW-1:0];
      c.y_end   = y2[CW-1:0];
      c.color   = color;
      cmd_queue.push_back(c);
   endtask

   // Step commands carry junk in the unused fields.
   task automatic queue_steps(input int n);
      line_cmd_type c;
      repeat (n) begin
         c.opcode  = lpg_pkg::OP_STEP;
         c.x_start = CW'($urandom);
         c.y_start = CW'($urandom);
         c.x_end   = CW'($urandom);
         c.y_end   = CW'($urandom);
         c.color   = $urandom;
         cmd_queue.push_back(c);
      end
   endtask

   function automatic int signed_span(input int lo, input int hi);
      int m;
      m = $urandom_range(lo, hi);
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // Mostly well-formed lines with random content, walked to the end or a
   // little past it; some abandoned early, some huge, some plain noise.
   task automatic queue_random_line();
      int x1, y1, dx, dy, reach, len, pick, mx, my;
      line_cmd_type c;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // Full-range endpoints: usually a long walk, cut short by the next start.
         queue_start(any_coord(), any_coord(), any_coord(), any_coord(), $urandom);
         queue_steps($urandom_range(2, 30));
         return;
      end
      if (pick < 16) begin
         repeat ($urandom_range(1, 4)) begin
            c.opcode  = 1'($urandom_range(0, 1));
            c.x_start = CW'($urandom);
            c.y_start = CW'($urandom);
            c.x_end   = CW'($urandom);
            c.y_end   = CW'($urandom);
            c.color   = $urandom;
            cmd_queue.push_back(c);
         end
         return;
      end
      x1 = any_coord();
      y1 = any_coord();
      reach = ($urandom_range(0, 24) == 0) ? 200 : 16;
      if (pick < 40) begin
         dx = int'($urandom_range(0, 2)) - 1;
         dy = signed_span(0, reach);
      end else if (pick < 64) begin
         dy = int'($urandom_range(0, 2)) - 1;
         dx = signed_span(2, reach);
      end else begin
         dx = signed_span(2, reach);
         dy = signed_span(2, reach);
      end
      queue_start(x1, y1, x1 + dx, y1 + dy, $urandom);
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      len = ((mx > my) ? mx : my) + 1;
      if ($urandom_range(0, 9) == 0)
         queue_steps($urandom_range(0, len - 1));
      else
         queue_steps(len + $urandom_range(0, 1));
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_opcode   = lpg_pkg::OP_START;
      req_x_start  = '0;
      req_y_start  = '0;
      req_x_end    = '0;
      req_y_end    = '0;
      req_color_in = '0;
      rsp_stall    = 1'b0;

      // Directed: step while idle, empty line, column at the most negative x
      // with the last step past its end, row at the top of the range cut short
      // by a new start, a short walk, and two full-range walks.
      queue_steps(1);
      queue_start(5, 5, 5, 5, 32'h0000_0000);
      queue_steps(1);
      queue_start(-32768, 10, -32767, 7, 32'hFFFF_FFFF);
      queue_steps(4);
      queue_start(32767, -32768, 32760, -32767, 32'h1234_5678);
      queue_steps(3);
      queue_start(0, 0, -3, 5, 32'hA5A5_5A5A);
      queue_steps(7);
      queue_start(-32768, -32768, 32767, 32767, 32'h0000_0000);
      queue_steps(2);
      queue_start(32767, 32767, -32768, -32768, 32'hFFFF_FFFF);
      queue_steps(2);

      while (cmd_queue.size() < CMD_TARGET)
         queue_random_line();
      total_cmds = cmd_queue.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every command to transfer and every pixel to come back.
      while (n_accepted < total_cmds)
         @(negedge clock);
      while (pixel_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (n_errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
